@@ rtl/partitioned_union_find_link_unit_defines.svh @@
// Assertion macros for the checker file of the link unit.
// Both macros sample on the rising edge of clock.
`ifndef PARTITIONED_UNION_FIND_LINK_UNIT_DEFINES_SVH
`define PARTITIONED_UNION_FIND_LINK_UNIT_DEFINES_SVH

// Property that is ignored while reset is high.
`define PUFLU_ASSERT_RUN(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("link unit check failed");

// Property that must also hold across reset.
`define PUFLU_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("link unit reset check failed");

`endif

@@ rtl/puflu_pkg.sv @@
package puflu_pkg;

   localparam int ID_W  = 16;
   localparam int OWN_W = 4;

   localparam int LOCAL_POINTS_DEF = 4096;
   localparam int TOTAL_POINTS_DEF = 65536;

   // Command codes carried on the request side.
   localparam logic [1:0] CMD_UNIFY    = 2'd0;
   localparam logic [1:0] CMD_LOAD_PAR = 2'd1;
   localparam logic [1:0] CMD_LOAD_OWN = 2'd2;
   localparam logic [1:0] CMD_NOP      = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_LINKED  = 2'd0;
   localparam logic [1:0] STAT_JOINED  = 2'd1;
   localparam logic [1:0] STAT_FORWARD = 2'd2;
   localparam logic [1:0] STAT_RANGE   = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_PART_BASE = 2'd0;
   localparam logic [1:0] CSR_OWN_PROC  = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAR,
      ST_OWN,
      ST_FIN,
      ST_EMIT
   } state_type;

   // One access to each table per cycle.
   typedef struct packed {
      logic            par_we;
      logic            par_re;
      logic [ID_W-1:0] par_slot;
      logic [ID_W-1:0] par_wdata;
      logic            own_we;
      logic            own_re;
      logic [ID_W-1:0] own_id;
      logic [OWN_W-1:0] own_wdata;
   } tbl_req_type;

endpackage

@@ rtl/puflu_tables.sv @@
module puflu_tables #(
   parameter int LOCAL_POINTS = puflu_pkg::LOCAL_POINTS_DEF,
   parameter int TOTAL_POINTS = puflu_pkg::TOTAL_POINTS_DEF
) (
   input  logic                     clock,
   input  puflu_pkg::tbl_req_type   tbl_req,
   output logic [puflu_pkg::ID_W-1:0]  par_rdata,
   output logic [puflu_pkg::OWN_W-1:0] own_rdata
);
   import puflu_pkg::*;

   localparam int PAR_AW = (LOCAL_POINTS > 1) ? $clog2(LOCAL_POINTS) : 1;
   localparam int OWN_AW = (TOTAL_POINTS > 1) ? $clog2(TOTAL_POINTS) : 1;

   logic [ID_W-1:0]  par_mem [LOCAL_POINTS];
   logic [OWN_W-1:0] own_mem [TOTAL_POINTS];
   logic [ID_W-1:0]  par_rdata_ff;
   logic [OWN_W-1:0] own_rdata_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.par_we) begin
         par_mem[tbl_req.par_slot[PAR_AW-1:0]] <= tbl_req.par_wdata;
      end
      if (tbl_req.par_re) begin
         par_rdata_ff <= par_mem[tbl_req.par_slot[PAR_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.own_we) begin
         own_mem[tbl_req.own_id[OWN_AW-1:0]] <= tbl_req.own_wdata;
      end
      if (tbl_req.own_re) begin
         own_rdata_ff <= own_mem[tbl_req.own_id[OWN_AW-1:0]];
      end
   end

   assign par_rdata = par_rdata_ff;
   assign own_rdata = own_rdata_ff;

endmodule

@@ rtl/partitioned_union_find_link_unit.sv @@
// Link unit for one partition of a distributed union-find (links go to larger ids).
// The req channel carries one word per command: req_tuser is the command (unify,
// load parent entry, load owner entry, no-op); req_tdata holds x, y, table index and
// table value. Loads in range produce no word; a unify always produces one word on
// the rsp channel with a status in rsp_tuser and, for a forward, the pair and the
// destination partition in rsp_tdata. The csr channel writes the partition base and
// this partition's number, and is always ready.
// An in-range load or a no-op leaves the block idle, and the next word can follow at
// once. A unify climbs L parent links, each one a parent-table read and an owner-table
// read on synchronous memories. A link, an already-joined pair or a range error on the
// walk goes straight to the emit state; a forward decided at a parent check passes the
// finish state while the destination owner is read, as does a walk that stops on a
// parent owned elsewhere at or above x. A range error on a load or on y goes from idle
// to the emit state. The next command is accepted in the cycle after the word is registered.
// A finished word sits in the rsp output register; the next command is accepted
// while it waits, and only a second result waits for the receiver to take the first.
// Reset clears the control state and sets the base to 0 and the partition number to
// 1. Table contents are not cleared: each entry must be loaded before it is used.
module partitioned_union_find_link_unit #(
   parameter int LOCAL_POINTS = puflu_pkg::LOCAL_POINTS_DEF,
   parameter int TOTAL_POINTS = puflu_pkg::TOTAL_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_x, point_y, table_index, table_value
   input  logic [1:0]  req_tuser,   // cmd
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // fwd_first, fwd_second, dest_process, zero pad
   output logic [1:0]  rsp_tuser,   // status
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import puflu_pkg::*;

   localparam int PAR_AW = (LOCAL_POINTS > 1) ? $clog2(LOCAL_POINTS) : 1;

   // Control state.
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Configuration.
   logic [ID_W-1:0]  part_base_ff;
   logic [OWN_W-1:0] own_proc_ff;

   // Walk registers.
   logic [ID_W-1:0]   x_ff, x_in;
   logic [ID_W-1:0]   root_ff, root_in;
   logic [PAR_AW-1:0] rslot_ff, rslot_in;

   // Pending result and output register.
   logic [1:0]       res_status_ff, res_status_in;
   logic [ID_W-1:0]  res_first_ff, res_first_in;
   logic [ID_W-1:0]  res_second_ff, res_second_in;
   logic [OWN_W-1:0] res_dest_ff, res_dest_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]  rsp_first_ff, rsp_first_in;
   logic [ID_W-1:0]  rsp_second_ff, rsp_second_in;
   logic [OWN_W-1:0] rsp_dest_ff, rsp_dest_in;

   // Request fields.
   logic [1:0]      cmd_w;
   logic [ID_W-1:0] x_w, y_w, idx_w, val_w;
   logic            in_acc;

   // Table access.
   tbl_req_type      tbl_req;
   logic [ID_W-1:0]  par_w;
   logic [OWN_W-1:0] own_w;

   // Decision terms.
   logic [ID_W-1:0]   loc_id;
   logic [ID_W:0]     loc_diff;
   logic              loc_hit;
   logic [PAR_AW-1:0] loc_slot;
   logic climb, is_root, own_match, out_free;
   logic par_in_tot, x_in_tot, idx_in_tot;
   logic root_lt_x, root_eq_x, par_lt_x;

   assign cmd_w = req_tuser;
   assign x_w   = req_tdata[15:0];
   assign y_w   = req_tdata[31:16];
   assign idx_w = req_tdata[47:32];
   assign val_w = req_tdata[63:48];

   assign req_tready = (state_ff == ST_IDLE);
   assign in_acc     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   puflu_tables #(
      .LOCAL_POINTS(LOCAL_POINTS),
      .TOTAL_POINTS(TOTAL_POINTS)
   ) u_tables (
      .clock     (clock),
      .tbl_req   (tbl_req),
      .par_rdata (par_w),
      .own_rdata (own_w)
   );

   // One shared range check against the local window: y or the table index while
   // idle, the freshly read parent while checking ownership.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         loc_id = (cmd_w == CMD_UNIFY) ? y_w : idx_w;
      end else begin
         loc_id = par_w;
      end
   end

   assign loc_diff = {1'b0, loc_id} - {1'b0, part_base_ff};
   assign loc_hit  = !loc_diff[ID_W] && (loc_diff < (ID_W+1)'(LOCAL_POINTS));
   assign loc_slot = loc_diff[PAR_AW-1:0];

   assign climb      = root_ff < par_w;
   assign is_root    = root_ff == par_w;
   assign own_match  = own_w == own_proc_ff;
   assign root_lt_x  = root_ff < x_ff;
   assign root_eq_x  = root_ff == x_ff;
   assign par_lt_x   = par_w < x_ff;
   assign par_in_tot = {1'b0, par_w} < (ID_W+1)'(TOTAL_POINTS);
   assign x_in_tot   = {1'b0, x_ff} < (ID_W+1)'(TOTAL_POINTS);
   assign idx_in_tot = {1'b0, idx_w} < (ID_W+1)'(TOTAL_POINTS);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               case (cmd_w)
                  CMD_UNIFY:    state_in = loc_hit ? ST_PAR : ST_EMIT;
                  CMD_LOAD_PAR: state_in = loc_hit ? ST_IDLE : ST_EMIT;
                  CMD_LOAD_OWN: state_in = idx_in_tot ? ST_IDLE : ST_EMIT;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_PAR: begin
            if (climb) begin
               state_in = par_in_tot ? ST_OWN : ST_EMIT;
            end else if (is_root) begin
               if (root_lt_x || root_eq_x || !x_in_tot) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FIN;
               end
            end else if (par_lt_x) begin
               state_in = par_in_tot ? ST_FIN : ST_EMIT;
            end else begin
               state_in = x_in_tot ? ST_FIN : ST_EMIT;
            end
         end
         ST_OWN: begin
            if (own_match) begin
               state_in = loc_hit ? ST_PAR : ST_EMIT;
            end else if (par_lt_x) begin
               state_in = ST_EMIT;
            end else begin
               state_in = x_in_tot ? ST_FIN : ST_EMIT;
            end
         end
         ST_FIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Table accesses and register updates.
   always_comb begin
      tbl_req       = '0;
      x_in          = x_ff;
      root_in       = root_ff;
      rslot_in      = rslot_ff;
      res_status_in = res_status_ff;
      res_first_in  = res_first_ff;
      res_second_in = res_second_ff;
      res_dest_in   = res_dest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_dest_in   = rsp_dest_ff;

      case (state_ff)
         ST_IDLE: begin
            // Any result decided here is an out-of-range error.
            res_status_in = STAT_RANGE;
            res_first_in  = '0;
            res_second_in = '0;
            res_dest_in   = '0;
            if (in_acc) begin
               case (cmd_w)
                  CMD_UNIFY: begin
                     x_in            = x_w;
                     root_in         = y_w;
                     rslot_in        = loc_slot;
                     tbl_req.par_re   = loc_hit;
                     tbl_req.par_slot = ID_W'(loc_slot);
                  end
                  CMD_LOAD_PAR: begin
                     tbl_req.par_we    = loc_hit;
                     tbl_req.par_slot  = ID_W'(loc_slot);
                     tbl_req.par_wdata = val_w;
                  end
                  CMD_LOAD_OWN: begin
                     tbl_req.own_we    = idx_in_tot;
                     tbl_req.own_id    = idx_w;
                     tbl_req.own_wdata = val_w[OWN_W-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAR: begin
            res_status_in = STAT_RANGE;
            res_first_in  = '0;
            res_second_in = '0;
            res_dest_in   = '0;
            if (climb) begin
               // Ask who owns the larger parent before climbing to it.
               tbl_req.own_re = par_in_tot;
               tbl_req.own_id = par_w;
            end else if (is_root) begin
               if (root_lt_x) begin
                  tbl_req.par_we    = 1'b1;
                  tbl_req.par_slot  = ID_W'(rslot_ff);
                  tbl_req.par_wdata = x_ff;
                  res_status_in     = STAT_LINKED;
               end else if (root_eq_x) begin
                  res_status_in = STAT_JOINED;
               end else if (x_in_tot) begin
                  tbl_req.own_re = 1'b1;
                  tbl_req.own_id = x_ff;
                  res_status_in  = STAT_FORWARD;
                  res_first_in   = root_ff;
                  res_second_in  = x_ff;
               end
            end else if (par_lt_x) begin
               if (par_in_tot) begin
                  tbl_req.own_re = 1'b1;
                  tbl_req.own_id = par_w;
                  res_status_in  = STAT_FORWARD;
                  res_first_in   = x_ff;
                  res_second_in  = par_w;
               end
            end else if (x_in_tot) begin
               tbl_req.own_re = 1'b1;
               tbl_req.own_id = x_ff;
               res_status_in  = STAT_FORWARD;
               res_first_in   = par_w;
               res_second_in  = x_ff;
            end
         end
         ST_OWN: begin
            res_status_in = STAT_RANGE;
            res_first_in  = '0;
            res_second_in = '0;
            res_dest_in   = '0;
            if (own_match) begin
               if (loc_hit) begin
                  root_in          = par_w;
                  rslot_in         = loc_slot;
                  tbl_req.par_re   = 1'b1;
                  tbl_req.par_slot = ID_W'(loc_slot);
               end
            end else if (par_lt_x) begin
               // The owner just read is already the destination.
               res_status_in = STAT_FORWARD;
               res_first_in  = x_ff;
               res_second_in = par_w;
               res_dest_in   = own_w;
            end else if (x_in_tot) begin
               tbl_req.own_re = 1'b1;
               tbl_req.own_id = x_ff;
               res_status_in  = STAT_FORWARD;
               res_first_in   = par_w;
               res_second_in  = x_ff;
            end
         end
         ST_FIN: begin
            res_dest_in = own_w;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_first_in  = res_first_ff;
               rsp_second_in = res_second_ff;
               rsp_dest_in   = res_dest_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         part_base_ff <= '0;
         own_proc_ff  <= OWN_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PART_BASE: part_base_ff <= csr_data;
               CSR_OWN_PROC:  own_proc_ff  <= csr_data[OWN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      root_ff       <= root_in;
      rslot_ff      <= rslot_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
      res_dest_ff   <= res_dest_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_dest_ff   <= rsp_dest_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_dest_ff, rsp_second_ff, rsp_first_ff};

endmodule

@@ rtl/puflu_checker.sv @@
`include "partitioned_union_find_link_unit_defines.svh"

module puflu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready
);
   import puflu_pkg::*;

   // A word that is not taken stays offered.
   `PUFLU_ASSERT_RUN(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // Reset leaves the block idle with no word pending.
   `PUFLU_ASSERT_ALWAYS(a_reset_idle, reset |=> req_tready && !rsp_tvalid)

   // A no-op does not occupy the sequencer.
   `PUFLU_ASSERT_RUN(a_nop_free, req_tvalid && req_tready && req_tuser == CMD_NOP |=> req_tready)

   // A unify always keeps the block busy after it is accepted.
   `PUFLU_ASSERT_RUN(a_unify_busy, req_tvalid && req_tready && req_tuser == CMD_UNIFY |=> !req_tready)

endmodule

bind partitioned_union_find_link_unit puflu_checker u_puflu_checker (.*);
